>>> src/rgp_pkg.sv
// Shared types, constants and register codes of the RGB-D gradient pixel selector.
package rgp_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int COL_W         = 10;
  localparam int ROW_W         = 12;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 17;
  localparam int LINE_W        = 48;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH_GRD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH_GRD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INT_GRD   = 3'd5;

  localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [11:0] RST_IMAGE_HEIGHT  = 12'd480;
  localparam logic [15:0] RST_MAX_DEPTH     = 16'hFFFF;
  localparam logic [16:0] RST_MAX_DEPTH_GRD = 17'h1FFFF;
  localparam logic [16:0] RST_MIN_DEPTH_GRD = 17'd0;
  localparam logic [9:0]  RST_MIN_INT_GRD   = 10'd0;

  typedef logic [2:0][2:0][7:0]  iwin_t;
  typedef logic [2:0][2:0][15:0] dwin_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [11:0] image_height;
    logic [15:0] max_depth;
    logic [16:0] max_depth_grd;
    logic [16:0] min_depth_grd;
    logic [9:0]  min_int_grd;
  } rgp_cfg_t;

  typedef struct packed {
    iwin_t            iwin;
    dwin_t            dwin;
    logic             emit_a;
    logic             emit_b;
    logic             lb_a;
    logic             lb_b;
    logic             tb;
    logic             bb;
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } rgp_item_t;

endpackage

>>> src/rgp_line_mem.sv
// Single-port-write, registered-read line buffer memory.
module rgp_line_mem #(
  parameter int DEPTH = rgp_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = rgp_pkg::LINE_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] line_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      line_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= line_mem[raddr];
    end
  end

endmodule

>>> src/rgp_window.sv
// Raster counters, line buffer read-modify-write and 3x3 window update.
module rgp_window #(
  parameter int MAX_WIDTH = rgp_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rgp_pkg::rgp_cfg_t  cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [7:0]         in_intensity,
  input  logic [15:0]        in_depth_mm,
  input  logic               item_rdy,
  output logic               item_load,
  output rgp_pkg::rgp_item_t item
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int XW = (AW + 1 > 11) ? AW + 1 : 11;

  logic [AW-1:0]                 col_r, col_nxt;
  logic [rgp_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic                          s1_v_r;
  logic [AW-1:0]                 s1_idx_r;
  logic [7:0]                    s1_iv_r;
  logic [15:0]                   s1_dv_r;
  logic                          s1_emit_a_r, s1_emit_b_r, s1_lb_a_r, s1_lb_b_r;
  logic                          s1_tb_r, s1_bb_r, s1_last_r;
  logic [rgp_pkg::COL_W-1:0]     s1_col_r;
  logic [rgp_pkg::ROW_W-1:0]     s1_row_r;
  logic                          fwd_r;
  logic [rgp_pkg::LINE_W-1:0]    fwd_data_r;
  rgp_pkg::iwin_t                iwin_r, iwin_nxt;
  rgp_pkg::dwin_t                dwin_r, dwin_nxt;

  logic                          acc, adv, last, end_frame;
  logic [XW-1:0]                 wx, wm1;
  logic [rgp_pkg::LINE_W-1:0]    rd_data, line_word, wr_data;

  assign acc      = in_valid && !in_stall;
  assign adv      = s1_v_r && item_rdy;
  assign in_stall = s1_v_r && !item_rdy;

  always_comb begin
    wx = XW'(cfg.image_width);
    if (wx == '0) begin
      wm1 = '0;
    end else if (wx > XW'(MAX_WIDTH)) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = wx - XW'(1);
    end
    last      = XW'(col_r) >= wm1;
    end_frame = in_operation || (row_r >= cfg.image_height);
    col_nxt   = last ? '0 : col_r + AW'(1);
    row_nxt   = last ? (end_frame ? '0 : row_r + rgp_pkg::ROW_W'(1)) : row_r;
  end

  rgp_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW), .DW(rgp_pkg::LINE_W)) u_mem (
    .clk   (clk),
    .we    (adv),
    .waddr (s1_idx_r),
    .wdata (wr_data),
    .re    (acc),
    .raddr (col_r),
    .rdata (rd_data)
  );

  // word: intensity above, intensity centre, depth above, depth centre
  assign line_word = fwd_r ? fwd_data_r : rd_data;
  assign wr_data   = {line_word[39:32], s1_iv_r, line_word[15:0], s1_dv_r};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      iwin_nxt[r][0] = iwin_r[r][1];
      iwin_nxt[r][1] = iwin_r[r][2];
      dwin_nxt[r][0] = dwin_r[r][1];
      dwin_nxt[r][1] = dwin_r[r][2];
    end
    iwin_nxt[0][2] = line_word[47:40];
    iwin_nxt[1][2] = line_word[39:32];
    iwin_nxt[2][2] = s1_iv_r;
    dwin_nxt[0][2] = line_word[31:16];
    dwin_nxt[1][2] = line_word[15:0];
    dwin_nxt[2][2] = s1_dv_r;
  end

  assign item_load   = adv;
  assign item.iwin   = iwin_nxt;
  assign item.dwin   = dwin_nxt;
  assign item.emit_a = s1_emit_a_r;
  assign item.emit_b = s1_emit_b_r;
  assign item.lb_a   = s1_lb_a_r;
  assign item.lb_b   = s1_lb_b_r;
  assign item.tb     = s1_tb_r;
  assign item.bb     = s1_bb_r;
  assign item.last   = s1_last_r;
  assign item.col    = s1_col_r;
  assign item.row    = s1_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
      iwin_r <= '0;
      dwin_r <= '0;
    end else begin
      if (acc) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        s1_v_r <= 1'b1;
        fwd_r  <= adv && (s1_idx_r == col_r);
      end else if (adv) begin
        s1_v_r <= 1'b0;
        fwd_r  <= 1'b0;
      end
      if (adv) begin
        iwin_r <= iwin_nxt;
        dwin_r <= dwin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fwd_data_r  <= wr_data;
      s1_idx_r    <= col_r;
      s1_iv_r     <= in_operation ? 8'd0 : in_intensity;
      s1_dv_r     <= in_operation ? 16'd0 : in_depth_mm;
      s1_emit_a_r <= (row_r != '0) && (col_r != '0);
      s1_emit_b_r <= (row_r != '0) && last;
      s1_lb_a_r   <= col_r == AW'(1);
      s1_lb_b_r   <= col_r == '0;
      s1_tb_r     <= row_r == rgp_pkg::ROW_W'(1);
      s1_bb_r     <= end_frame;
      s1_last_r   <= last;
      s1_col_r    <= rgp_pkg::COL_W'(col_r);
      s1_row_r    <= row_r - rgp_pkg::ROW_W'(1);
    end
  end

  a_acc_fills: assert property (@(posedge clk) disable iff (!rst_n) acc |=> s1_v_r)
    else $error("accepted request did not reach the line buffer stage");
  a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n) fwd_r |-> s1_v_r)
    else $error("forwarded line word without a request in flight");

endmodule

>>> src/rgp_emit.sv
// Gradient, validity and selection per result, and the output register.
module rgp_emit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rgp_pkg::rgp_cfg_t                cfg,
  input  logic                             item_load,
  input  rgp_pkg::rgp_item_t               item,
  output logic                             item_rdy,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rgp_pkg::COL_W-1:0]        out_column,
  output logic [rgp_pkg::ROW_W-1:0]        out_row,
  output logic signed [10:0]               out_intensity_grad_x,
  output logic signed [10:0]               out_intensity_grad_y,
  output logic signed [16:0]               out_depth_grad_x,
  output logic signed [16:0]               out_depth_grad_y,
  output logic                             out_depth_grad_x_valid,
  output logic                             out_depth_grad_y_valid,
  output logic                             out_selected,
  output logic                             out_end_of_run
);

  rgp_pkg::rgp_item_t        it_r;
  logic                      pa_r, pb_r;
  logic                      out_valid_r;
  logic [rgp_pkg::COL_W-1:0] col_r;
  logic [rgp_pkg::ROW_W-1:0] row_r;
  logic signed [10:0]        gx_r, gy_r;
  logic signed [16:0]        dx_r, dy_r;
  logic                      vx_r, vy_r, sel_r, eor_r;

  logic                      out_ld, quiet, lb, rb, tb, bb, eor;
  logic [1:0]                cl, cm, cr;
  logic [1:0]                ir [3];
  logic [1:0]                ic [3];
  logic [1:0]                dr0, dr2, dc0, dc2;
  logic [7:0]                pix [3][3];
  logic signed [11:0]        gx, gy, gxa, gya;
  logic [15:0]               zl, zr, za, zb, z;
  logic                      vx, vy, sel;
  logic signed [17:0]        dx, dy, dxa, dya;
  logic [rgp_pkg::COL_W-1:0] col;

  // a request without results passes without touching the pending ones
  assign quiet    = !item.emit_a && !item.emit_b;
  assign out_ld   = (pa_r || pb_r) && (!out_valid_r || !out_stall);
  assign item_rdy = !(pa_r || pb_r) || (out_ld && !(pa_r && pb_r)) || quiet;

  always_comb begin
    cl  = pa_r ? 2'd0 : 2'd1;
    cm  = pa_r ? 2'd1 : 2'd2;
    cr  = 2'd2;
    lb  = pa_r ? it_r.lb_a : it_r.lb_b;
    rb  = !pa_r;
    tb  = it_r.tb;
    bb  = it_r.bb;
    eor = pa_r ? !it_r.last : 1'b1;
    col = pa_r ? it_r.col - rgp_pkg::COL_W'(1) : it_r.col;

    ir[0] = tb ? (bb ? 2'd1 : 2'd2) : 2'd0;
    ir[1] = 2'd1;
    ir[2] = bb ? (tb ? 2'd1 : 2'd0) : 2'd2;
    ic[0] = lb ? (rb ? cm : cr) : cl;
    ic[1] = cm;
    ic[2] = rb ? (lb ? cm : cl) : cr;
    dr0   = tb ? 2'd1 : 2'd0;
    dr2   = bb ? 2'd1 : 2'd2;
    dc0   = lb ? cm : cl;
    dc2   = rb ? cm : cr;

    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        pix[a][b] = it_r.iwin[ir[a]][ic[b]];
      end
    end

    gx = ($signed({4'd0, pix[0][2]}) - $signed({4'd0, pix[0][0]}))
       + (($signed({4'd0, pix[1][2]}) - $signed({4'd0, pix[1][0]})) <<< 1)
       + ($signed({4'd0, pix[2][2]}) - $signed({4'd0, pix[2][0]}));
    gy = ($signed({4'd0, pix[2][0]}) - $signed({4'd0, pix[0][0]}))
       + (($signed({4'd0, pix[2][1]}) - $signed({4'd0, pix[0][1]})) <<< 1)
       + ($signed({4'd0, pix[2][2]}) - $signed({4'd0, pix[0][2]}));
    gxa = gx[11] ? -gx : gx;
    gya = gy[11] ? -gy : gy;

    zl = it_r.dwin[1][dc0];
    zr = it_r.dwin[1][dc2];
    za = it_r.dwin[dr0][cm];
    zb = it_r.dwin[dr2][cm];
    z  = it_r.dwin[1][cm];
    vx = (zl != '0) && (zr != '0);
    vy = (za != '0) && (zb != '0);
    dx = vx ? ($signed({2'd0, zr}) - $signed({2'd0, zl})) : '0;
    dy = vy ? ($signed({2'd0, zb}) - $signed({2'd0, za})) : '0;
    dxa = dx[17] ? -dx : dx;
    dya = dy[17] ? -dy : dy;

    sel = vx && vy && (z != '0) && (z < cfg.max_depth)
       && (dxa < $signed({1'b0, cfg.max_depth_grd}))
       && (dya < $signed({1'b0, cfg.max_depth_grd}))
       && ((gxa > $signed({2'd0, cfg.min_int_grd}))
        || (gya > $signed({2'd0, cfg.min_int_grd}))
        || (dxa > $signed({1'b0, cfg.min_depth_grd}))
        || (dya > $signed({1'b0, cfg.min_depth_grd})));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_r        <= 1'b0;
      pb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_load && !quiet) begin
        pa_r <= item.emit_a;
        pb_r <= item.emit_b;
      end else if (out_ld) begin
        if (pa_r) begin
          pa_r <= 1'b0;
        end else begin
          pb_r <= 1'b0;
        end
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_load && !quiet) begin
      it_r <= item;
    end
    if (out_ld) begin
      col_r <= col;
      row_r <= it_r.row;
      gx_r  <= 11'(gx);
      gy_r  <= 11'(gy);
      dx_r  <= 17'(dx);
      dy_r  <= 17'(dy);
      vx_r  <= vx;
      vy_r  <= vy;
      sel_r <= sel;
      eor_r <= eor;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_column             = col_r;
  assign out_row                = row_r;
  assign out_intensity_grad_x   = gx_r;
  assign out_intensity_grad_y   = gy_r;
  assign out_depth_grad_x       = dx_r;
  assign out_depth_grad_y       = dy_r;
  assign out_depth_grad_x_valid = vx_r;
  assign out_depth_grad_y_valid = vy_r;
  assign out_selected           = sel_r;
  assign out_end_of_run         = eor_r;

  a_second_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !eor_r |-> pb_r)
    else $error("row-end result lost after its predecessor");
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(pa_r || pb_r) |-> item_rdy)
    else $error("empty result stage refused a request");

endmodule

>>> src/rgbd_gradient_pixel_selector.sv
// Top level of the RGB-D gradient pixel selector: configuration registers and datapath.
// Streams raster (intensity, depth) pixels and, one row behind, reports for each pixel
// the raw 3x3 Sobel intensity gradients (reflect-101 borders), the depth central
// differences with their valid flags (clamped borders) and a selection flag. Requests
// are taken one per clock unless stalled; each costs one line buffer read and one write
// in the same two-stage pipeline, with the write forwarded to a following read of the
// same column. The last pixel of a row yields two results and the first pixel of the
// next row none; that pixel passes the result stage without waiting, so one request and
// one result per clock are sustained when the sink never stalls. Each request passes the
// line buffer stage, result stage and output registers before it reaches the outputs.
// Follow each frame with a row of flush requests (operation = 1) to release the last row.
module rgbd_gradient_pixel_selector #(
  parameter int MAX_WIDTH = rgp_pkg::MAX_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rgp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rgp_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  logic [7:0]                           in_intensity,
  input  logic [15:0]                          in_depth_mm,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rgp_pkg::COL_W-1:0]            out_column,
  output logic [rgp_pkg::ROW_W-1:0]            out_row,
  output logic signed [10:0]                   out_intensity_grad_x,
  output logic signed [10:0]                   out_intensity_grad_y,
  output logic signed [16:0]                   out_depth_grad_x,
  output logic signed [16:0]                   out_depth_grad_y,
  output logic                                 out_depth_grad_x_valid,
  output logic                                 out_depth_grad_y_valid,
  output logic                                 out_selected,
  output logic                                 out_end_of_run
);

  rgp_pkg::rgp_cfg_t  cfg_r;
  rgp_pkg::rgp_item_t item;
  logic               item_rdy, item_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width   <= rgp_pkg::RST_IMAGE_WIDTH;
      cfg_r.image_height  <= rgp_pkg::RST_IMAGE_HEIGHT;
      cfg_r.max_depth     <= rgp_pkg::RST_MAX_DEPTH;
      cfg_r.max_depth_grd <= rgp_pkg::RST_MAX_DEPTH_GRD;
      cfg_r.min_depth_grd <= rgp_pkg::RST_MIN_DEPTH_GRD;
      cfg_r.min_int_grd   <= rgp_pkg::RST_MIN_INT_GRD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rgp_pkg::REG_IMAGE_WIDTH:   cfg_r.image_width   <= cfg_data[10:0];
        rgp_pkg::REG_IMAGE_HEIGHT:  cfg_r.image_height  <= cfg_data[11:0];
        rgp_pkg::REG_MAX_DEPTH:     cfg_r.max_depth     <= cfg_data[15:0];
        rgp_pkg::REG_MAX_DEPTH_GRD: cfg_r.max_depth_grd <= cfg_data;
        rgp_pkg::REG_MIN_DEPTH_GRD: cfg_r.min_depth_grd <= cfg_data;
        rgp_pkg::REG_MIN_INT_GRD:   cfg_r.min_int_grd   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  rgp_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_intensity (in_intensity),
    .in_depth_mm  (in_depth_mm),
    .item_rdy     (item_rdy),
    .item_load    (item_load),
    .item         (item)
  );

  rgp_emit u_emit (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .item_load              (item_load),
    .item                   (item),
    .item_rdy               (item_rdy),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_column             (out_column),
    .out_row                (out_row),
    .out_intensity_grad_x   (out_intensity_grad_x),
    .out_intensity_grad_y   (out_intensity_grad_y),
    .out_depth_grad_x       (out_depth_grad_x),
    .out_depth_grad_y       (out_depth_grad_y),
    .out_depth_grad_x_valid (out_depth_grad_x_valid),
    .out_depth_grad_y_valid (out_depth_grad_y_valid),
    .out_selected           (out_selected),
    .out_end_of_run         (out_end_of_run)
  );

endmodule
